// ===== src/drvu_pkg.sv =====
package drvu_pkg;

   // Widths fixed by the item fields.
   localparam int COST_W = 16;
   localparam int IDX_W  = 3;

   localparam logic [COST_W-1:0] COST_NONE = '1;
   localparam logic [COST_W-1:0] COST_MAX  = 16'h7FFF;

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_ADVERTISE = 2'd1,
      CMD_RESET     = 2'd2,
      CMD_LOOKUP    = 2'd3
   } cmd_type;

   // One table row: cost, next hop and whether a next hop is set.
   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              hop_set;
      logic [IDX_W-1:0]  hop;
   } row_type;

   localparam row_type ROW_EMPTY = '{cost: COST_NONE, hop_set: 1'b0, hop: '0};

   // Operands of one Bellman-Ford relaxation.
   typedef struct packed {
      row_type           row_d;
      logic              valid_d;
      row_type           row_n;
      logic              valid_n;
      logic [COST_W-1:0] cost;
      logic [IDX_W-1:0]  nbr;
   } relax_in_type;

   typedef struct packed {
      logic [COST_W-1:0] relaxed_cost;
      logic              update;
   } relax_out_type;

   // A row never written since reset reads as the reset contents.
   function automatic row_type row_eff(input row_type r, input logic written);
      return written ? r : ROW_EMPTY;
   endfunction

endpackage

// ===== src/drvu_ifs.sv =====
interface drvu_req_if;
   logic                                valid;
   logic                                ready;
   drvu_pkg::cmd_type                   command;
   logic [drvu_pkg::IDX_W-1:0]          dest_index;
   logic [drvu_pkg::IDX_W-1:0]          neighbor_index;
   logic signed [drvu_pkg::COST_W-1:0]  cost;
   logic                                last_element;

   modport source (output valid, command, dest_index, neighbor_index, cost, last_element,
                   input ready);
   modport sink (input valid, command, dest_index, neighbor_index, cost, last_element,
                 output ready);
endinterface

interface drvu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [drvu_pkg::COST_W-1:0]  route_cost;
   logic [drvu_pkg::IDX_W-1:0]          next_hop;
   logic                                has_route;
   logic                                table_changed;

   modport source (output valid, route_cost, next_hop, has_route, table_changed,
                   input ready);
   modport sink (input valid, route_cost, next_hop, has_route, table_changed,
                 output ready);
endinterface

interface drvu_csr_if;
   logic                        valid;
   logic                        ready;
   logic [drvu_pkg::IDX_W-1:0]  self_index;

   modport source (output valid, self_index, input ready);
   modport sink (input valid, self_index, output ready);
endinterface

// ===== src/distance_vector_route_update.sv =====
// Distance-vector routing table with Bellman-Ford relaxation.
// Channels: req_chan takes one command per transfer (load, advertisement
// element, neighbor-loss reset, lookup); rsp_chan returns exactly one result
// per command, in order; csr_chan writes self_index and is always ready.
// Write csr_chan only while no command is in flight.
// A load, lookup or advertisement element is a table read, then a modify
// and write back; the last element of an advertisement adds a step of its
// own, since the link cost to the sender is written back through the single
// live-table write port. A neighbor-loss reset copies the initial table
// into the live table one entry per cycle over its one read port.
// One command is in work at a time; req_chan is ready only between commands.
// Results sit in an output register, so a finished result waits there while
// the next command is taken; a command that needs the output register stalls
// until rsp_chan takes the previous result.
// Reset: all entries unreachable and valid, no next hops, no neighbors,
// self_index 0. No clearing pass is needed after reset.
module distance_vector_route_update #(
   parameter int ROUTERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   drvu_req_if.sink    req_chan,
   drvu_rsp_if.source  rsp_chan,
   drvu_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(ROUTERS);
   localparam logic [AW-1:0] LAST_IDX = AW'(ROUTERS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LAST,
      ST_COPY,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // Accepted command.
   drvu_pkg::cmd_type             cmd_ff;
   logic [drvu_pkg::IDX_W-1:0]    d_ff;
   logic [drvu_pkg::IDX_W-1:0]    n_ff;
   logic [drvu_pkg::COST_W-1:0]   c_ff;
   logic                          last_ff;

   logic [drvu_pkg::IDX_W-1:0]    self_ff;
   logic [ROUTERS-1:0]            live_valid_ff;
   logic [ROUTERS-1:0]            init_valid_ff;
   logic [ROUTERS-1:0]            mark_ff;
   logic                          change_ff;
   logic [drvu_pkg::COST_W-1:0]   adv_self_ff;
   drvu_pkg::row_type             new_row_ff;
   drvu_pkg::row_type             hold_row_ff;
   logic [AW-1:0]                 cnt_ff;
   logic                          copy_wr_ff;
   logic [AW-1:0]                 copy_addr_ff;

   logic                          rsp_valid_ff;
   logic [drvu_pkg::COST_W-1:0]   rsp_cost_ff;
   logic [drvu_pkg::IDX_W-1:0]    rsp_hop_ff;
   logic                          rsp_has_ff;
   logic                          rsp_changed_ff;

   logic                          req_fire;
   logic                          out_free;
   logic [AW-1:0]                 d_addr;
   logic [AW-1:0]                 n_addr;
   logic                          d_ok;
   logic                          n_ok;
   logic                          is_self;
   logic                          fix_n;
   logic                          vd;
   logic                          vn;
   logic                          adv_write;
   logic                          no_emit;
   logic                          step;
   logic                          kill;
   logic [ROUTERS-1:0]            kill_mask;
   logic [ROUTERS-1:0]            iv_in;

   drvu_pkg::row_type             live_rd_a;
   drvu_pkg::row_type             live_rd_b;
   drvu_pkg::row_type             init_rd;
   drvu_pkg::row_type             load_row;
   drvu_pkg::row_type             new_row_d;
   drvu_pkg::relax_in_type        rlx_in;
   drvu_pkg::relax_out_type       rlx_out;

   logic                          live_we;
   logic [AW-1:0]                 live_wa;
   drvu_pkg::row_type             live_wrow;
   logic                          init_we;
   logic                          init_re;
   logic [AW-1:0]                 init_ra;

   drvu_pkg::row_type             res_row;
   logic                          res_valid;
   logic                          rsp_load;
   logic                          rsp_changed_in;
   logic                          rsp_has_in;
   logic [drvu_pkg::COST_W-1:0]   rsp_cost_in;
   logic [drvu_pkg::IDX_W-1:0]    rsp_hop_in;

   // Handshakes.
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;

   // Index decode.
   assign d_addr  = AW'(d_ff);
   assign n_addr  = AW'(n_ff);
   assign d_ok    = (32'(d_ff) < ROUTERS);
   assign n_ok    = (32'(n_ff) < ROUTERS);
   assign is_self = (d_ff == self_ff);

   // A sender whose initial entry was invalidated becomes valid again.
   assign fix_n = (cmd_ff == drvu_pkg::CMD_ADVERTISE) & n_ok & ~init_valid_ff[n_addr];
   assign vn    = (n_ok & live_valid_ff[n_addr]) | fix_n;
   assign vd    = (d_ok & live_valid_ff[d_addr]) | (fix_n & (d_ff == n_ff));

   assign rlx_in = '{row_d: live_rd_a, valid_d: vd, row_n: live_rd_b, valid_n: vn,
                     cost: c_ff, nbr: n_ff};

   drvu_relax u_relax (
      .rin  (rlx_in),
      .rout (rlx_out)
   );

   assign new_row_d = '{cost:    rlx_out.relaxed_cost,
                        hop_set: rlx_out.update | live_rd_a.hop_set,
                        hop:     rlx_out.update ? n_ff : live_rd_a.hop};
   assign load_row  = '{cost: c_ff, hop_set: 1'b1, hop: d_ff};
   assign adv_write = (cmd_ff == drvu_pkg::CMD_ADVERTISE) & n_ok & ~is_self & d_ok;

   // Commands that do not deliver a result from the execute cycle.
   assign no_emit = (cmd_ff == drvu_pkg::CMD_RESET) |
                    ((cmd_ff == drvu_pkg::CMD_ADVERTISE) & last_ff);
   assign step    = (state_ff == ST_EXEC) & (no_emit | out_free);

   // Neighbor loss: invalidate a reachable neighbor in the initial table.
   assign kill = n_ok & mark_ff[n_addr] & init_valid_ff[n_addr] & ~init_rd.cost[15];
   always_comb begin
      kill_mask = '0;
      if (kill) begin
         kill_mask[n_addr] = 1'b1;
      end
   end
   assign iv_in = init_valid_ff & ~kill_mask;

   // Live table write port: element or load, link cost on the last element, copy.
   always_comb begin
      live_we   = 1'b0;
      live_wa   = d_addr;
      live_wrow = new_row_d;
      if (copy_wr_ff) begin
         live_we   = 1'b1;
         live_wa   = copy_addr_ff;
         live_wrow = init_rd;
      end else if (step & (cmd_ff == drvu_pkg::CMD_LOAD) & d_ok) begin
         live_we   = 1'b1;
         live_wrow = load_row;
      end else if (step & adv_write) begin
         live_we   = 1'b1;
      end else if ((state_ff == ST_LAST) & out_free & n_ok) begin
         live_we   = 1'b1;
         live_wa   = n_addr;
         live_wrow = '{cost:    adv_self_ff,
                       hop_set: (d_ff == n_ff) ? new_row_ff.hop_set : live_rd_b.hop_set,
                       hop:     (d_ff == n_ff) ? new_row_ff.hop : live_rd_b.hop};
      end
   end

   drvu_live_mem #(.ROUTERS(ROUTERS)) u_live_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (AW'(req_chan.dest_index)),
      .rd_addr_b (AW'(req_chan.neighbor_index)),
      .rd_row_a  (live_rd_a),
      .rd_row_b  (live_rd_b),
      .wr_en     (live_we),
      .wr_addr   (live_wa),
      .wr_row    (live_wrow)
   );

   // Initial table: read the sender on transfer, or sweep during a copy.
   assign init_re = req_fire | (state_ff == ST_COPY);
   assign init_ra = (state_ff == ST_COPY) ? cnt_ff : AW'(req_chan.neighbor_index);
   assign init_we = step & (cmd_ff == drvu_pkg::CMD_LOAD) & d_ok;

   drvu_init_mem #(.ROUTERS(ROUTERS)) u_init_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (init_re),
      .rd_addr (init_ra),
      .rd_row  (init_rd),
      .wr_en   (init_we),
      .wr_addr (d_addr),
      .wr_row  (load_row)
   );

   // Result selection for the destination entry after the command.
   always_comb begin
      res_row        = live_rd_a;
      res_valid      = vd;
      rsp_changed_in = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            rsp_load = step & ~no_emit;
            if (cmd_ff == drvu_pkg::CMD_LOAD) begin
               res_row   = load_row;
               res_valid = 1'b1;
            end else if (adv_write) begin
               res_row = new_row_d;
            end
         end
         ST_LAST: begin
            rsp_load       = out_free;
            rsp_changed_in = change_ff;
            res_valid      = d_ok & live_valid_ff[d_addr];
            res_row        = new_row_ff;
            if (n_ok & (d_ff == n_ff)) begin
               res_row.cost = adv_self_ff;
            end
         end
         ST_EMIT: begin
            rsp_load  = out_free;
            res_valid = d_ok & live_valid_ff[d_addr];
            res_row   = hold_row_ff;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_has_in  = d_ok & res_valid & res_row.hop_set;
   assign rsp_cost_in = (d_ok & res_valid) ? res_row.cost : drvu_pkg::COST_NONE;
   assign rsp_hop_in  = rsp_has_in ? res_row.hop : '0;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff <= '0;
      end else if (csr_chan.valid) begin
         self_ff <= csr_chan.self_index;
      end
   end

   // Accepted command fields; a negative cost counts as unreachable.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_chan.command;
         d_ff    <= req_chan.dest_index;
         n_ff    <= req_chan.neighbor_index;
         c_ff    <= req_chan.cost[15] ? drvu_pkg::COST_NONE : req_chan.cost;
         last_ff <= req_chan.last_element;
      end
   end

   // Copy write pipeline, capture of the destination row, and the row held for the last element.
   always_ff @(posedge clock) begin
      copy_addr_ff <= cnt_ff;
      if (copy_wr_ff & (copy_addr_ff == d_addr)) begin
         hold_row_ff <= init_rd;
      end
      if (step) begin
         new_row_ff <= adv_write ? new_row_d : live_rd_a;
      end
   end

   // Sequencer, table control state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_valid_ff <= '1;
         init_valid_ff <= '1;
         mark_ff       <= '0;
         change_ff     <= 1'b0;
         adv_self_ff   <= drvu_pkg::COST_NONE;
         cnt_ff        <= '0;
         copy_wr_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         copy_wr_ff <= (state_ff == ST_COPY);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (step) begin
                  unique case (cmd_ff)
                     drvu_pkg::CMD_LOAD: begin
                        if (d_ok) begin
                           live_valid_ff[d_addr] <= 1'b1;
                           init_valid_ff[d_addr] <= 1'b1;
                           mark_ff[d_addr]       <= 1'b1;
                        end
                        state_ff <= ST_IDLE;
                     end
                     drvu_pkg::CMD_ADVERTISE: begin
                        if (fix_n) begin
                           init_valid_ff[n_addr] <= 1'b1;
                           live_valid_ff[n_addr] <= 1'b1;
                        end
                        if (fix_n | (adv_write & rlx_out.update)) begin
                           change_ff <= 1'b1;
                        end
                        if (n_ok & is_self) begin
                           adv_self_ff <= c_ff;
                        end
                        state_ff <= last_ff ? ST_LAST : ST_IDLE;
                     end
                     drvu_pkg::CMD_RESET: begin
                        init_valid_ff <= iv_in;
                        live_valid_ff <= iv_in;
                        cnt_ff        <= '0;
                        state_ff      <= ST_COPY;
                     end
                     drvu_pkg::CMD_LOOKUP: begin
                        state_ff <= ST_IDLE;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_LAST: begin
               if (out_free) begin
                  change_ff   <= 1'b0;
                  adv_self_ff <= drvu_pkg::COST_NONE;
                  state_ff    <= ST_IDLE;
               end
            end
            ST_COPY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // Output register: loaded with a result, emptied by a transfer.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cost_ff    <= rsp_cost_in;
         rsp_hop_ff     <= rsp_hop_in;
         rsp_has_ff     <= rsp_has_in;
         rsp_changed_ff <= rsp_changed_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.route_cost    = rsp_cost_ff;
   assign rsp_chan.next_hop      = rsp_hop_ff;
   assign rsp_chan.has_route     = rsp_has_ff;
   assign rsp_chan.table_changed = rsp_changed_ff;

   // After a copy the live valid bits match the initial ones.
   a_copy_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> live_valid_ff == init_valid_ff)
      else $error("live valid bits differ from initial ones after copy");

   // The changed flag is only reported at the end of an advertisement.
   a_changed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_changed_in |-> state_ff == ST_LAST)
      else $error("table_changed reported outside the last element");

   // Ending an advertisement clears the pending change and the self cost.
   a_adv_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAST && out_free |=> adv_self_ff == drvu_pkg::COST_NONE && !change_ff)
      else $error("advertisement state not cleared at its end");

endmodule

// ===== src/drvu_live_mem.sv =====
module drvu_live_mem #(
   parameter int ROUTERS = 8,
   localparam int AW = $clog2(ROUTERS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output drvu_pkg::row_type rd_row_a,
   output drvu_pkg::row_type rd_row_b,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  drvu_pkg::row_type wr_row
);

   drvu_pkg::row_type mem [ROUTERS];
   logic [ROUTERS-1:0] written_ff;
   drvu_pkg::row_type rd_a_ff;
   drvu_pkg::row_type rd_b_ff;
   logic              rd_a_wr_ff;
   logic              rd_b_wr_ff;

   // Live table storage with two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_a_ff    <= mem[rd_addr_a];
         rd_b_ff    <= mem[rd_addr_b];
         rd_a_wr_ff <= written_ff[rd_addr_a];
         rd_b_wr_ff <= written_ff[rd_addr_b];
      end
   end

   // Rows not yet written read as the reset contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_row_a = drvu_pkg::row_eff(rd_a_ff, rd_a_wr_ff);
   assign rd_row_b = drvu_pkg::row_eff(rd_b_ff, rd_b_wr_ff);

endmodule

// ===== src/drvu_init_mem.sv =====
module drvu_init_mem #(
   parameter int ROUTERS = 8,
   localparam int AW = $clog2(ROUTERS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output drvu_pkg::row_type rd_row,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  drvu_pkg::row_type wr_row
);

   drvu_pkg::row_type mem [ROUTERS];
   logic [ROUTERS-1:0] written_ff;
   drvu_pkg::row_type rd_ff;
   logic              rd_wr_ff;

   // Initial table storage with one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_ff    <= mem[rd_addr];
         rd_wr_ff <= written_ff[rd_addr];
      end
   end

   // Rows not yet written read as the reset contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_row = drvu_pkg::row_eff(rd_ff, rd_wr_ff);

endmodule

// ===== src/drvu_relax.sv =====
module drvu_relax (
   input  drvu_pkg::relax_in_type  rin,
   output drvu_pkg::relax_out_type rout
);

   logic [drvu_pkg::COST_W-1:0] orig;
   logic [drvu_pkg::COST_W-1:0] via;
   logic [drvu_pkg::COST_W-1:0] sum_raw;
   logic [drvu_pkg::COST_W-1:0] sum;
   logic                        blocked;
   logic                        better;
   logic                        tie;

   // Effective costs: an invalid entry counts as unreachable.
   assign orig = rin.valid_d ? rin.row_d.cost : drvu_pkg::COST_NONE;
   assign via  = rin.valid_n ? rin.row_n.cost : drvu_pkg::COST_NONE;

   // Both operands are below 2^15 here, so the sum fits in 16 bits before saturation.
   assign sum_raw = {1'b0, via[14:0]} + {1'b0, rin.cost[14:0]};
   assign sum     = sum_raw[15] ? drvu_pkg::COST_MAX : sum_raw;

   // Minimum with the lower-numbered sender winning a tie.
   assign blocked = via[15] | rin.cost[15];
   assign better  = orig[15] | (sum[14:0] < orig[14:0]);
   assign tie     = (sum[14:0] == orig[14:0]) & rin.row_d.hop_set & (rin.row_d.hop > rin.nbr);

   assign rout.update       = ~blocked & (better | tie);
   assign rout.relaxed_cost = (~blocked & better) ? sum : orig;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int COST_W        = drvu_pkg::COST_W;
   localparam int IDX_W         = drvu_pkg::IDX_W;
   localparam int ROUTERS       = 8;
   localparam int NO_HOP        = -1;
   localparam int UNREACH       = -1;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = ROUTERS + 8;
   localparam int MAX_REPORTS   = 10;

   // One result as the block reports it.
   typedef struct packed {
      logic signed [COST_W-1:0] route_cost;
      logic [IDX_W-1:0]         next_hop;
      logic                     has_route;
      logic                     table_changed;
   } route_answer_type;

   logic clock;
   logic reset;

   drvu_req_if req_chan ();
   drvu_rsp_if rsp_chan ();
   drvu_csr_if csr_chan ();

   distance_vector_route_update #(.ROUTERS(ROUTERS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Routing table model: live and initial tables, neighbor marks and the
   // bookkeeping of the advertisement in progress.
   int               live_cost [ROUTERS] = '{default: UNREACH};
   int               live_hop  [ROUTERS] = '{default: NO_HOP};
   bit               live_ok   [ROUTERS] = '{default: 1'b1};
   int               base_cost [ROUTERS] = '{default: UNREACH};
   int               base_hop  [ROUTERS] = '{default: NO_HOP};
   bit               base_ok   [ROUTERS] = '{default: 1'b1};
   bit               nbr_mark  [ROUTERS] = '{default: 1'b0};
   bit               chg_pending   = 1'b0;
   int               self_adv_cost = UNREACH;
   logic [IDX_W-1:0] self_id       = '0;

   route_answer_type pending_answers [$];

   int send_gap_pct    = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold        = 0;
   int cycle_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int ads_ended       = 0;
   int changes_seen    = 0;
   int resets_sent     = 0;
   int mismatches      = 0;

   // An invalid entry reads as unreachable.
   function automatic int eff_cost(input int i);
      return live_ok[i] ? live_cost[i] : UNREACH;
   endfunction

   // One Bellman-Ford relaxation for an advertisement element.
   function automatic void relax_entry(input int dest, input int nbr, input int c);
      int  orig, via, sum, nc;
      bit  upd;
      upd = 1'b0;
      // A sender that was lost comes back on its first element.
      if (!base_ok[nbr]) begin
         base_ok[nbr] = 1'b1;
         live_ok[nbr] = 1'b1;
         chg_pending  = 1'b1;
      end
      if (dest == self_id) begin
         self_adv_cost = c;
         return;
      end
      orig = eff_cost(dest);
      via  = eff_cost(nbr);
      if (via < 0 || c < 0) begin
         nc = orig;
      end else begin
         sum = via + c;
         if (sum > int'(drvu_pkg::COST_MAX)) sum = int'(drvu_pkg::COST_MAX);
         if (orig < 0 || sum < orig) begin
            upd = 1'b1;
            nc  = sum;
         end else if (sum == orig) begin
            // On a tie only a lower-numbered sender takes over an existing hop.
            upd = (live_hop[dest] != NO_HOP) && (live_hop[dest] > nbr);
            nc  = sum;
         end else begin
            nc = orig;
         end
      end
      live_cost[dest] = nc;
      if (upd) begin
         live_hop[dest] = nbr;
         chg_pending    = 1'b1;
      end
   endfunction

   // Applies one accepted command to the model and returns the route it reports.
   function automatic route_answer_type route_table_step(input drvu_pkg::cmd_type cmd,
         input int dest, input int nbr, input logic [COST_W-1:0] raw, input bit last);
      int               c;
      bit               has;
      route_answer_type ans;
      c = raw[COST_W-1] ? UNREACH : int'(raw);
      ans.table_changed = 1'b0;
      case (cmd)
         drvu_pkg::CMD_LOAD: begin
            live_cost[dest] = c;
            live_hop[dest]  = dest;
            live_ok[dest]   = 1'b1;
            base_cost[dest] = c;
            base_hop[dest]  = dest;
            base_ok[dest]   = 1'b1;
            nbr_mark[dest]  = 1'b1;
         end
         drvu_pkg::CMD_ADVERTISE: begin
            relax_entry(dest, nbr, c);
            if (last) begin
               live_cost[nbr]    = self_adv_cost;
               ans.table_changed = chg_pending;
               chg_pending       = 1'b0;
               self_adv_cost     = UNREACH;
            end
         end
         drvu_pkg::CMD_RESET: begin
            if (nbr_mark[nbr] && base_ok[nbr] && base_cost[nbr] >= 0) base_ok[nbr] = 1'b0;
            live_cost = base_cost;
            live_hop  = base_hop;
            live_ok   = base_ok;
         end
         default: begin
         end
      endcase
      has            = live_ok[dest] && live_hop[dest] != NO_HOP;
      ans.route_cost = COST_W'(eff_cost(dest));
      ans.has_route  = has;
      ans.next_hop   = has ? IDX_W'(live_hop[dest]) : '0;
      return ans;
   endfunction

   function automatic string describe(input route_answer_type a);
      return $sformatf("cost %0d hop %0d route %0b changed %0b",
                       a.route_cost, a.next_hop, a.has_route, a.table_changed);
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_answers.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check each result transfer, then track configuration and command transfers.
   always @(posedge clock) begin : watch_channels
      route_answer_type got, want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.route_cost, rsp_chan.next_hop,
                    rsp_chan.has_route, rsp_chan.table_changed};
            results_checked++;
            if (got.table_changed) changes_seen++;
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result with nothing outstanding: %s", $time, describe(got));
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: result %0d differs: expected %s, got %s",
                              $time, results_checked, describe(want), describe(got));
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready) self_id = csr_chan.self_index;
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.command == drvu_pkg::CMD_ADVERTISE && req_chan.last_element)
               ads_ended++;
            if (req_chan.command == drvu_pkg::CMD_RESET) resets_sent++;
            pending_answers.insert(pending_answers.size(), route_table_step(
               req_chan.command, int'(req_chan.dest_index), int'(req_chan.neighbor_index),
               req_chan.cost, req_chan.last_element));
         end
      end
   end

   // Offers one command, with a random gap first, and waits for its transfer.
   // Valid stays high afterwards so that back-to-back commands need no toggle.
   task automatic send_item(input drvu_pkg::cmd_type cmd, input int dest, input int nbr,
                            input logic [COST_W-1:0] cost, input bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.command        <= cmd;
      req_chan.dest_index     <= IDX_W'(dest);
      req_chan.neighbor_index <= IDX_W'(nbr);
      req_chan.cost           <= cost;
      req_chan.last_element   <= last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Drops valid and waits until every result is in and the block has settled.
   task automatic wait_for_answers();
      req_chan.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_self(input int id);
      wait_for_answers();
      csr_chan.valid      <= 1'b1;
      csr_chan.self_index <= IDX_W'(id);
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // Costs lean toward small values so that sums collide and ties happen.
   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(9))
         0, 1, 2, 3: return COST_W'($urandom_range(12));
         4:          return drvu_pkg::COST_NONE;
         5:          return drvu_pkg::COST_MAX - COST_W'($urandom_range(3));
         6:          return COST_W'($urandom_range(300));
         default:    return COST_W'($urandom);
      endcase
   endfunction

   // One advertisement over consecutive destinations, last element flagged
   // unless the sequence is meant to be cut short.
   task automatic send_advertisement(input int nbr, input int first_dest, input int count,
                                     input bit finish);
      for (int k = 0; k < count; k++)
         send_item(drvu_pkg::CMD_ADVERTISE, first_dest + k, nbr, pick_cost(),
                   finish && (k == count - 1));
   endtask

   // Loads, advertisements and their corner cases, losses and lookups.
   task automatic test_directed_cases();
      send_item(drvu_pkg::CMD_LOOKUP, 0, 0, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_LOAD, 1, 0, 16'd5, 1'b0);
      send_item(drvu_pkg::CMD_LOAD, 3, 7, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_LOAD, 4, 0, drvu_pkg::COST_MAX, 1'b0);
      send_item(drvu_pkg::CMD_LOAD, 5, 0, drvu_pkg::COST_NONE, 1'b0);
      send_item(drvu_pkg::CMD_LOAD, 6, 0, 16'h8000, 1'b0);
      // Sender 3 reaches 0, reports its own cost, and sends an unreachable cost.
      send_item(drvu_pkg::CMD_ADVERTISE, 0, 3, 16'd5, 1'b0);
      send_item(drvu_pkg::CMD_ADVERTISE, 2, 3, 16'd1, 1'b0);
      send_item(drvu_pkg::CMD_ADVERTISE, 7, 3, 16'h8001, 1'b1);
      // Unknown sender 7 leaves a cost with no next hop on its own entry.
      send_item(drvu_pkg::CMD_ADVERTISE, 2, 7, 16'd4, 1'b1);
      // An equal cost never replaces an entry that has no next hop.
      send_item(drvu_pkg::CMD_ADVERTISE, 7, 3, 16'd3, 1'b1);
      // Sender 1: tie won by the lower index, saturating sum, unreachable entries.
      send_item(drvu_pkg::CMD_ADVERTISE, 0, 1, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_ADVERTISE, 4, 1, drvu_pkg::COST_MAX, 1'b0);
      send_item(drvu_pkg::CMD_ADVERTISE, 5, 1, 16'd3, 1'b0);
      send_item(drvu_pkg::CMD_ADVERTISE, 6, 1, 16'd0, 1'b1);
      send_item(drvu_pkg::CMD_LOOKUP, 0, 5, 16'hFFFF, 1'b1);
      send_item(drvu_pkg::CMD_LOOKUP, 7, 2, 16'h7FFF, 1'b0);
      // Losses: a reachable neighbor, a non-neighbor, an unreachable neighbor.
      send_item(drvu_pkg::CMD_RESET, 1, 1, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_LOOKUP, 1, 0, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_RESET, 2, 7, 16'd0, 1'b0);
      send_item(drvu_pkg::CMD_RESET, 5, 5, 16'd0, 1'b1);
      // The lost neighbor comes back with its next advertisement.
      send_item(drvu_pkg::CMD_ADVERTISE, 3, 1, 16'd0, 1'b1);
      send_item(drvu_pkg::CMD_LOAD, 2, 6, 16'd7, 1'b1);
      send_item(drvu_pkg::CMD_LOOKUP, 2, 7, 16'hAAAA, 1'b1);
   endtask

   // Mostly well-formed advertisements, mixed with loads, lookups, losses
   // and unstructured commands.
   task automatic test_random_traffic(input int count);
      int goal, pick, first, len;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            if ($urandom_range(2) == 0) begin
               first = 0;
               len   = ROUTERS;
            end else begin
               first = $urandom_range(ROUTERS - 1);
               len   = $urandom_range(ROUTERS - first, 1);
            end
            send_advertisement($urandom_range(ROUTERS - 1), first, len,
                               $urandom_range(19) != 0);
         end else if (pick < 70) begin
            send_item(drvu_pkg::CMD_LOAD, $urandom_range(ROUTERS - 1),
                      $urandom_range(ROUTERS - 1),
                      ($urandom_range(3) == 0) ? pick_cost() : COST_W'($urandom_range(20)),
                      1'($urandom_range(1)));
         end else if (pick < 80) begin
            send_item(drvu_pkg::CMD_LOOKUP, $urandom_range(ROUTERS - 1),
                      $urandom_range(ROUTERS - 1), COST_W'($urandom),
                      1'($urandom_range(1)));
         end else if (pick < 85) begin
            send_item(drvu_pkg::CMD_RESET, $urandom_range(ROUTERS - 1),
                      $urandom_range(ROUTERS - 1), COST_W'($urandom),
                      1'($urandom_range(1)));
         end else begin
            send_item(drvu_pkg::cmd_type'($urandom_range(3)), $urandom_range(ROUTERS - 1),
                      $urandom_range(ROUTERS - 1), COST_W'($urandom),
                      1'($urandom_range(1)));
         end
      end
   endtask

   // The receiver holds off for a long stretch while commands keep coming,
   // so the output register fills and the block stalls its input.
   task automatic test_output_backpressure();
      rsp_hold = 400;
      test_random_traffic(60);
      wait_for_answers();
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.command        <= drvu_pkg::CMD_LOAD;
      req_chan.dest_index     <= '0;
      req_chan.neighbor_index <= '0;
      req_chan.cost           <= '0;
      req_chan.last_element   <= 1'b0;
      csr_chan.valid          <= 1'b0;
      csr_chan.self_index     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Sender idles rarely, receiver often.
      send_gap_pct  = 10;
      rsp_stall_pct = 76;
      configure_self(2);
      test_directed_cases();
      configure_self(0);
      test_random_traffic(330);

      // Sender idles often, receiver rarely.
      send_gap_pct  = 76;
      rsp_stall_pct = 10;
      configure_self(7);
      test_random_traffic(330);

      // Neither side idles.
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      configure_self(4);
      test_random_traffic(300);
      configure_self(5);
      test_output_backpressure();

      $display("Run covered %0d commands: %0d advertisements ended, %0d neighbor losses,",
               items_sent, ads_ended, resets_sent);
      $display("%0d results checked, %0d reporting a table change, five self_index values.",
               results_checked, changes_seen);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
